// ----- sv/sasfr_pkg.sv -----
// Types and constants shared by the six-axis sensor frame receiver files.
package sasfr_pkg;

    localparam logic [7:0]  CMD_AUTO_ON = 8'hAE;
    localparam logic [7:0]  START_BYTE  = 8'h96;
    localparam logic [7:0]  END_BYTE    = 8'h8D;
    localparam logic [15:0] AXIS_OFFSET = 16'd8192;
    localparam logic [13:0] SUM_MASK    = 14'h3FFF;
    localparam int          SUM_SPAN    = 13;
    localparam int          FRAME_LEN   = 16;
    localparam int          AXES        = 6;

    // bytes kept in registers: a frame's last byte is the closing item itself
    localparam int          STORE_N     = FRAME_LEN - 1;
    localparam int          STORE_IDX_W = $clog2(STORE_N);

    typedef enum logic [1:0] {
        MODE_RESET = 2'd0,
        MODE_INIT  = 2'd1,
        MODE_RUN   = 2'd2
    } t_mode;

    typedef struct packed {
        logic       req_type;
        logic [7:0] rx_byte;
        logic       burst_end;
    } t_in_item;

    typedef struct packed {
        logic               tx_valid;
        logic [7:0]         tx_byte;
        logic               frame_ok;
        logic               connected;
        logic signed [15:0] axis_x;
        logic signed [15:0] axis_y;
        logic signed [15:0] axis_z;
        logic signed [15:0] axis_a;
        logic signed [15:0] axis_b;
        logic signed [15:0] axis_c;
    } t_out_item;

endpackage

// ----- sv/six_axis_sensor_frame_receiver.sv -----
// Six-axis sensor frame receiver: burst collection, mode control and frame decode.
// Timing: a start request or a burst-closing byte yields its item on o_out_valid in the
// cycle after acceptance; other bytes yield no item.
// Throughput: one input item per cycle; the single output register is refilled in the
// same cycle it is drained, so o_in_ready drops only while an item waits downstream.
// Reset (synchronous, i_rst_n low): reset mode, empty burst, link down, axes zero,
// no output item pending.
module six_axis_sensor_frame_receiver #(
    parameter int BUF_BYTES = 17
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  sasfr_pkg::t_in_item   i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output sasfr_pkg::t_out_item  o_out_item
);
    import sasfr_pkg::*;

    localparam int CNT_W = $clog2(BUF_BYTES + 1);

    t_mode            r_mode, n_mode;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [13:0]      r_sum, n_sum;
    logic             r_link, n_link;
    logic [15:0]      r_axis [AXES];
    logic [15:0]      n_axis [AXES];
    logic [7:0]       r_buf  [STORE_N];
    t_out_item        r_out, n_out;
    logic             r_out_valid, n_out_valid;

    logic             w_acc;
    logic             w_close;
    logic [CNT_W-1:0] w_cnt_inc;
    logic [15:0]      w_got;
    logic             w_is_frame;
    logic             w_is_ack;
    logic             w_ok;

    assign o_in_ready  = ~r_out_valid | i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assign w_acc     = i_in_valid & o_in_ready;
    assign w_cnt_inc = r_cnt + CNT_W'(1);
    assign w_close   = i_in_item.burst_end | (w_cnt_inc == CNT_W'(BUF_BYTES));

    // received checksum is byte13*128 + byte14; can reach 16 bits and then never matches
    assign w_got      = {1'b0, r_buf[13], 7'b0} + 16'(r_buf[14]);
    assign w_is_frame = (r_cnt == CNT_W'(FRAME_LEN - 1)) && (r_buf[0] == START_BYTE) &&
                        (i_in_item.rx_byte == END_BYTE) && (w_got == {2'b0, r_sum});
    assign w_is_ack   = (r_cnt == CNT_W'(1)) && (r_buf[0] == CMD_AUTO_ON) &&
                        (i_in_item.rx_byte == END_BYTE);

    // next mode
    always_comb begin
        n_mode = r_mode;
        if (w_acc) begin
            if (!i_in_item.req_type) begin
                n_mode = MODE_INIT;
            end else if (w_close && r_mode == MODE_INIT && w_is_ack) begin
                n_mode = MODE_RUN;
            end
        end
    end

    // burst bookkeeping, link status, axes and the output item
    always_comb begin
        n_cnt       = r_cnt;
        n_sum       = r_sum;
        n_link      = r_link;
        n_axis      = r_axis;
        n_out       = r_out;
        n_out_valid = r_out_valid & ~i_out_ready;
        w_ok        = 1'b0;
        if (w_acc) begin
            if (!i_in_item.req_type) begin
                n_link = 1'b0;
                n_cnt  = '0;
                n_sum  = '0;
            end else if (w_close) begin
                unique case (r_mode)
                    MODE_INIT: begin
                    end
                    MODE_RUN: begin
                        if (w_is_frame) begin
                            for (int i = 0; i < AXES; i++) begin
                                n_axis[i] = ({1'b0, r_buf[1 + 2 * i], 7'b0} +
                                             16'(r_buf[2 + 2 * i])) - AXIS_OFFSET;
                            end
                            n_link = 1'b1;
                            w_ok   = 1'b1;
                        end else begin
                            n_link = 1'b0;
                        end
                    end
                    default: begin
                        n_link = 1'b0;
                    end
                endcase
                n_cnt = '0;
                n_sum = '0;
            end else begin
                n_cnt = w_cnt_inc;
                if (r_cnt < CNT_W'(SUM_SPAN)) begin
                    n_sum = (r_sum + 14'(i_in_item.rx_byte)) & SUM_MASK;
                end
            end

            if (!i_in_item.req_type || w_close) begin
                n_out_valid     = 1'b1;
                n_out.tx_valid  = ~i_in_item.req_type;
                n_out.tx_byte   = i_in_item.req_type ? 8'h00 : CMD_AUTO_ON;
                n_out.frame_ok  = w_ok;
                n_out.connected = n_link;
                n_out.axis_x    = $signed(n_axis[0]);
                n_out.axis_y    = $signed(n_axis[1]);
                n_out.axis_z    = $signed(n_axis[2]);
                n_out.axis_a    = $signed(n_axis[3]);
                n_out.axis_b    = $signed(n_axis[4]);
                n_out.axis_c    = $signed(n_axis[5]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_RESET;
            r_cnt       <= '0;
            r_sum       <= '0;
            r_link      <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < AXES; i++) begin
                r_axis[i] <= '0;
            end
        end else begin
            r_mode      <= n_mode;
            r_cnt       <= n_cnt;
            r_sum       <= n_sum;
            r_link      <= n_link;
            r_out_valid <= n_out_valid;
            r_axis      <= n_axis;
        end
    end

    // payload: burst bytes and the output item
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (w_acc && i_in_item.req_type && r_cnt < CNT_W'(STORE_N)) begin
            r_buf[r_cnt[STORE_IDX_W-1:0]] <= i_in_item.rx_byte;
        end
    end

endmodule

// ----- sv/sasfr_checker.sv -----
// Port-level checker for the six-axis sensor frame receiver, with its bind.
module sasfr_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_ready,
    input sasfr_pkg::t_in_item   i_in_item,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input sasfr_pkg::t_out_item  o_out_item
);
    import sasfr_pkg::*;

    // a waiting item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("output item changed while stalled");

    // a start request shows up as the command item in the next cycle
    a_start_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && !i_in_item.req_type |=>
        o_out_valid && o_out_item.tx_valid && o_out_item.tx_byte == CMD_AUTO_ON &&
        !o_out_item.frame_ok && !o_out_item.connected)
        else $error("start request did not produce the command item");

    // burst items carry no command byte
    a_burst_no_tx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.tx_valid |-> o_out_item.tx_byte == 8'h00)
        else $error("burst item carries a command byte");

    // a good frame always leaves the link up
    a_ok_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.frame_ok |-> o_out_item.connected)
        else $error("valid frame without connected");

endmodule

bind six_axis_sensor_frame_receiver sasfr_checker u_sasfr_checker (.*);

// ----- bench/tb_six_axis_sensor_frame_receiver.sv -----
// Self-checking testbench for the six-axis sensor frame receiver: directed table plus random bursts.
`timescale 1ns / 100ps

module tb_six_axis_sensor_frame_receiver;
    import sasfr_pkg::*;

    localparam int   BUF_N        = 17;
    localparam int   RANDOM_ITEMS = 600;
    localparam int   HOLD_AT      = 250;
    localparam int   SINK_HOLD    = 300;
    localparam int   STALL_LIMIT  = 2000;
    localparam int   DRAIN_CYCLES = 10;
    localparam logic REQ_START    = 1'b0;
    localparam logic REQ_BYTE     = 1'b1;

    typedef struct {
        t_in_item  item;
        bit        typed;
        t_out_item want;
    } stim_row_t;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_in_item  in_item   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_item;

    // frame decoder state, kept in step with accepted items
    t_mode                rx_mode;
    logic [7:0]           burst_buf [BUF_N];
    int                   burst_len;
    logic [13:0]          burst_sum;
    logic                 link_up_q;
    logic signed [15:0]   axis_q [AXES];

    t_out_item   pending_results[$];
    stim_row_t   directed_rows[$];
    logic [7:0]  frame_buf [BUF_N];
    int          fail_count    = 0;
    int          items_sent    = 0;
    int          src_calm      = 0;
    bit          sink_hold_req = 1'b0;

    six_axis_sensor_frame_receiver #(.BUF_BYTES(BUF_N)) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic t_out_item link_snapshot(input logic txv, input logic [7:0] txb,
                                                input logic ok);
        t_out_item r;
        r.tx_valid  = txv;
        r.tx_byte   = txb;
        r.frame_ok  = ok;
        r.connected = link_up_q;
        r.axis_x    = axis_q[0];
        r.axis_y    = axis_q[1];
        r.axis_z    = axis_q[2];
        r.axis_a    = axis_q[3];
        r.axis_b    = axis_q[4];
        r.axis_c    = axis_q[5];
        return r;
    endfunction

    task automatic decode_step(input t_in_item it, output bit has_res, output t_out_item res);
        logic ok;
        int   v;
        has_res = 1'b0;
        ok      = 1'b0;
        res     = '0;
        if (it.req_type == REQ_START) begin
            rx_mode   = MODE_INIT;
            link_up_q = 1'b0;
            burst_len = 0;
            burst_sum = '0;
            res       = link_snapshot(1'b1, CMD_AUTO_ON, 1'b0);
            has_res   = 1'b1;
        end else begin
            if (burst_len < BUF_N) begin
                burst_buf[burst_len] = it.rx_byte;
                if (burst_len < SUM_SPAN)
                    burst_sum = burst_sum + 14'(it.rx_byte);
                burst_len++;
            end
            if (it.burst_end || burst_len >= BUF_N) begin
                if (rx_mode == MODE_INIT) begin
                    if (burst_len == 2 && burst_buf[0] == CMD_AUTO_ON &&
                        burst_buf[1] == END_BYTE)
                        rx_mode = MODE_RUN;
                end else if (rx_mode == MODE_RUN) begin
                    if (burst_len == FRAME_LEN && burst_buf[0] == START_BYTE &&
                        burst_buf[15] == END_BYTE &&
                        int'(burst_buf[13]) * 128 + int'(burst_buf[14]) == int'(burst_sum))
                        ok = 1'b1;
                    if (ok) begin
                        for (int i = 0; i < AXES; i++) begin
                            v = int'(burst_buf[1 + 2 * i]) * 128 + int'(burst_buf[2 + 2 * i]);
                            axis_q[i] = 16'(v - int'(AXIS_OFFSET));
                        end
                    end
                    link_up_q = ok;
                end else begin
                    link_up_q = 1'b0;
                end
                burst_len = 0;
                burst_sum = '0;
                res       = link_snapshot(1'b0, 8'h00, ok);
                has_res   = 1'b1;
            end
        end
    endtask

    function automatic int next_gap();
        int r;
        if (src_calm > 0) begin
            src_calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            src_calm = $urandom_range(20, 60);
            return 0;
        end
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    // present one item, hold it until taken, then log what it should produce
    task automatic send_item(input t_in_item it, input bit typed, input t_out_item want);
        int        gap;
        bit        has_res;
        t_out_item res;
        gap = next_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        decode_step(it, has_res, res);
        if (has_res)
            pending_results.push_back(typed ? want : res);
        items_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        t_in_item it;
        it.req_type  = REQ_BYTE;
        it.rx_byte   = b;
        it.burst_end = last;
        send_item(it, 1'b0, '0);
    endtask

    task automatic send_start();
        t_in_item it;
        it.req_type  = REQ_START;
        it.rx_byte   = 8'($urandom_range(0, 255));
        it.burst_end = 1'($urandom_range(0, 1));
        send_item(it, 1'b0, '0);
    endtask

    task automatic send_ack();
        send_byte(CMD_AUTO_ON, 1'b0);
        send_byte(END_BYTE, 1'b1);
    endtask

    task automatic add_row(input logic req, input logic [7:0] b, input logic last,
                           input bit typed, input t_out_item want);
        stim_row_t row;
        row.item.req_type  = req;
        row.item.rx_byte   = b;
        row.item.burst_end = last;
        row.typed          = typed;
        row.want           = want;
        directed_rows.push_back(row);
    endtask

    // start byte, checksum and end byte around frame_buf[1..12]
    task automatic seal_frame(input bit alt_split);
        int s;
        frame_buf[0] = START_BYTE;
        s = 0;
        for (int k = 0; k < SUM_SPAN; k++)
            s += frame_buf[k];
        s = s & int'(SUM_MASK);
        // same checksum, low byte carrying an extra 128
        if (alt_split && s >= 128) begin
            frame_buf[13] = 8'((s >> 7) - 1);
            frame_buf[14] = 8'((s & 127) + 128);
        end else begin
            frame_buf[13] = 8'(s >> 7);
            frame_buf[14] = 8'(s & 127);
        end
        frame_buf[15] = END_BYTE;
    endtask

    task automatic randomize_frame();
        int r;
        for (int k = 1; k <= 2 * AXES; k++) begin
            r = $urandom_range(0, 9);
            frame_buf[k] = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom_range(0, 255));
        end
        frame_buf[16] = 8'($urandom_range(0, 255));
        seal_frame(1'($urandom_range(0, 1)));
    endtask

    task automatic send_frame(input int n, input logic close_last);
        for (int k = 0; k < n; k++)
            send_byte(frame_buf[k], close_last && (k == n - 1));
    endtask

    task automatic send_random_sequence();
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            randomize_frame();
            send_frame(FRAME_LEN, 1'b1);
        end else if (r < 58) begin
            randomize_frame();
            n = $urandom_range(0, FRAME_LEN - 1);
            frame_buf[n] ^= 8'($urandom_range(1, 255));
            send_frame(FRAME_LEN, 1'b1);
        end else if (r < 63) begin
            randomize_frame();
            send_frame($urandom_range(1, FRAME_LEN - 1), 1'b1);
        end else if (r < 68) begin
            // no burst_end: the buffer filling up closes the burst
            randomize_frame();
            send_frame(BUF_N, 1'b0);
        end else if (r < 73) begin
            // received checksum of 16384 or more never matches
            randomize_frame();
            frame_buf[13] = 8'($urandom_range(128, 255));
            send_frame(FRAME_LEN, 1'b1);
        end else if (r < 80) begin
            n = $urandom_range(1, 6);
            repeat (n) begin
                if ($urandom_range(0, 9) == 0)
                    send_start();
                else
                    send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 2) == 0);
            end
        end else if (r < 90) begin
            n = $urandom_range(0, 4);
            repeat (n) send_byte(8'($urandom_range(0, 255)), 1'b0);
            send_start();
            if ($urandom_range(0, 4) == 0)
                send_byte(8'($urandom_range(0, 255)), 1'b1);
            send_ack();
        end else begin
            send_ack();
        end
    endtask

    task automatic check_field(input string name, input logic signed [16:0] want,
                               input logic signed [16:0] got);
        if (want !== got) begin
            fail_count++;
            if (fail_count <= 10)
                $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk) begin : result_check
        t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("%0t: result item with nothing expected", $time);
            end else begin
                want = pending_results.pop_front();
                check_field("tx_valid", 17'(want.tx_valid), 17'(out_item.tx_valid));
                check_field("tx_byte", 17'(want.tx_byte), 17'(out_item.tx_byte));
                check_field("frame_ok", 17'(want.frame_ok), 17'(out_item.frame_ok));
                check_field("connected", 17'(want.connected), 17'(out_item.connected));
                check_field("axis_x", 17'(want.axis_x), 17'(out_item.axis_x));
                check_field("axis_y", 17'(want.axis_y), 17'(out_item.axis_y));
                check_field("axis_z", 17'(want.axis_z), 17'(out_item.axis_z));
                check_field("axis_a", 17'(want.axis_a), 17'(out_item.axis_a));
                check_field("axis_b", 17'(want.axis_b), 17'(out_item.axis_b));
                check_field("axis_c", 17'(want.axis_c), 17'(out_item.axis_c));
            end
        end
    end

    initial begin : sink_pace
        int r;
        int calm;
        calm = 0;
        forever begin
            @(posedge clk);
            if (sink_hold_req) begin
                sink_hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (SINK_HOLD) @(posedge clk);
                out_ready <= 1'b1;
            end else if (calm > 0) begin
                calm--;
                out_ready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 4) begin
                    calm = $urandom_range(20, 80);
                end else if (r < 7) begin
                    out_ready <= 1'b0;
                    repeat ($urandom_range(10, 40)) @(posedge clk);
                    out_ready <= 1'b1;
                end else begin
                    out_ready <= (r < 70);
                end
            end
        end
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle = 0;
            else
                idle++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : stimulus
        t_out_item quiet_res;
        t_out_item cmd_res;
        int        base;
        bit        hold_done;

        rx_mode   = MODE_RESET;
        burst_len = 0;
        burst_sum = '0;
        link_up_q = 1'b0;
        foreach (axis_q[i])
            axis_q[i] = '0;
        hold_done = 1'b0;

        quiet_res         = '0;
        cmd_res           = '0;
        cmd_res.tx_valid  = 1'b1;
        cmd_res.tx_byte   = CMD_AUTO_ON;

        // burst in reset mode, start (ignored fields at max), junk burst in init, acknowledge
        add_row(REQ_BYTE, 8'hFF, 1'b1, 1'b1, quiet_res);
        add_row(REQ_START, 8'hFF, 1'b1, 1'b1, cmd_res);
        add_row(REQ_BYTE, 8'h00, 1'b1, 1'b1, quiet_res);
        add_row(REQ_BYTE, CMD_AUTO_ON, 1'b0, 1'b0, '0);
        add_row(REQ_BYTE, END_BYTE, 1'b1, 1'b1, quiet_res);
        // data frame with axes at both extremes, zero, and in between
        frame_buf[1]  = 8'h00;  frame_buf[2]  = 8'h00;
        frame_buf[3]  = 8'hFF;  frame_buf[4]  = 8'hFF;
        frame_buf[5]  = 8'h7F;  frame_buf[6]  = 8'h7F;
        frame_buf[7]  = 8'h80;  frame_buf[8]  = 8'h80;
        frame_buf[9]  = 8'h40;  frame_buf[10] = 8'h00;
        frame_buf[11] = 8'h01;  frame_buf[12] = 8'h02;
        seal_frame(1'b0);
        for (int k = 0; k < FRAME_LEN; k++)
            add_row(REQ_BYTE, frame_buf[k], k == FRAME_LEN - 1, 1'b0, '0);
        // start request in the middle of a burst, then back to running
        add_row(REQ_BYTE, 8'h11, 1'b0, 1'b0, '0);
        add_row(REQ_START, 8'h00, 1'b0, 1'b0, '0);
        add_row(REQ_BYTE, CMD_AUTO_ON, 1'b0, 1'b0, '0);
        add_row(REQ_BYTE, END_BYTE, 1'b1, 1'b0, '0);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[k])
            send_item(directed_rows[k].item, directed_rows[k].typed, directed_rows[k].want);

        base = items_sent;
        while (items_sent - base < RANDOM_ITEMS) begin
            if (!hold_done && items_sent - base >= HOLD_AT) begin
                hold_done     = 1'b1;
                sink_hold_req = 1'b1;
            end
            send_random_sequence();
        end
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
